[design/rslseq_pkg.sv]
package rslseq_pkg;

    typedef enum logic [1:0] {
        LINK_UP    = 2'd0,
        LINK_DOWN  = 2'd1,
        LINK_OTHER = 2'd2
    } link_code_t;

    typedef enum logic [1:0] {
        REG_RED_INTERVAL  = 2'd0,
        REG_RED_STEP      = 2'd1,
        REG_BLUE_INTERVAL = 2'd2,
        REG_BLUE_STEP     = 2'd3
    } cfg_reg_t;

    localparam logic [7:0]  DUTY_FULL     = 8'd255;
    localparam logic [7:0]  RED_INT_RST   = 8'd40;
    localparam logic [7:0]  RED_STEP_RST  = 8'd4;
    localparam logic [7:0]  BLUE_INT_RST  = 8'd10;
    localparam logic [7:0]  BLUE_STEP_RST = 8'd8;

    localparam logic [11:0] LEVEL_MAX     = 12'd3000;
    localparam logic [11:0] SEG_ONE       = 12'd1000;
    localparam logic [11:0] SEG_TWO       = 12'd2000;

    // (51*d + 100) / 200 as a multiply by the rounded-up reciprocal of 200
    localparam logic [15:0] RAMP_BIAS     = 16'd100;
    localparam int          RAMP_SHIFT    = 24;
    localparam logic [16:0] RAMP_RECIP    = 17'd83887;

    typedef struct packed {
        logic       fire;
        logic [7:0] level;
    } fade_status_t;

    typedef struct packed {
        logic        powered;
        logic        show_level;
        logic [1:0]  link_state;
        logic        level_valid;
        logic [11:0] level;
    } tick_beat_t;

endpackage

[design/rslseq_fade.sv]
module rslseq_fade (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       tick,
    input  logic                       sel,
    input  logic [7:0]                 interval,
    input  logic [7:0]                 step,
    output rslseq_pkg::fade_status_t   status
);
    import rslseq_pkg::*;

    logic [7:0] level_reg, level_next;
    logic       falling_reg, falling_next;
    logic [7:0] elapsed_reg, elapsed_next;
    logic [7:0] elapsed_inc;
    logic [8:0] up_sum;
    logic       fire;

    // counter saturates so the first step after reset is immediate
    assign elapsed_inc = (elapsed_reg == DUTY_FULL) ? DUTY_FULL : elapsed_reg + 8'd1;
    assign fire        = sel && (elapsed_inc >= interval);
    assign up_sum      = {1'b0, level_reg} + {1'b0, step};

    always_comb
    begin
        level_next   = level_reg;
        falling_next = falling_reg;
        if (falling_reg)
        begin
            if (level_reg <= step)
            begin
                level_next   = 8'd0;
                falling_next = 1'b0;
            end
            else
            begin
                level_next = level_reg - step;
            end
        end
        else
        begin
            if (up_sum >= {1'b0, DUTY_FULL})
            begin
                level_next   = DUTY_FULL;
                falling_next = 1'b1;
            end
            else
            begin
                level_next = up_sum[7:0];
            end
        end
    end

    assign elapsed_next = fire ? 8'd0 : elapsed_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg   <= 8'd0;
            falling_reg <= 1'b0;
            elapsed_reg <= DUTY_FULL;
        end
        else if (tick)
        begin
            elapsed_reg <= elapsed_next;
            if (fire)
            begin
                level_reg   <= level_next;
                falling_reg <= falling_next;
            end
        end
    end

    assign status.fire  = fire;
    assign status.level = level_next;

    a_fire_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        tick && fire |=> elapsed_reg == 8'd0)
        else $error("elapsed count not restarted after a fade step");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !(tick && fire) |=> $stable(level_reg) && $stable(falling_reg))
        else $error("fade level moved without a step");

    a_top_turns: assert property (@(posedge clk) disable iff (!rst_n)
        tick && fire && level_next == DUTY_FULL |=> falling_reg)
        else $error("fade did not turn at full level");

endmodule

[design/rslseq_bar.sv]
module rslseq_bar (
    input  logic [11:0] level,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue
);
    import rslseq_pkg::*;

    logic [11:0] lvl;
    logic [11:0] seg_off;
    logic [9:0]  d;
    logic [15:0] num;
    logic [32:0] prod;
    logic [7:0]  ramp;
    logic        below_one;
    logic        below_two;

    assign lvl       = (level > LEVEL_MAX) ? LEVEL_MAX : level;
    assign below_one = lvl < SEG_ONE;
    assign below_two = lvl < SEG_TWO;

    // one shared ramp, fed by whichever segment the level sits in
    assign seg_off = below_one ? 12'd0 : (below_two ? SEG_ONE : SEG_TWO);
    assign d       = 10'(lvl - seg_off);
    assign num     = ({6'd0, d} << 5) + ({6'd0, d} << 4) + ({6'd0, d} << 1)
                   + {6'd0, d} + RAMP_BIAS;
    assign prod    = {1'b0, num} * {16'd0, RAMP_RECIP};
    assign ramp    = prod[RAMP_SHIFT +: 8];

    assign green = below_one ? ramp : DUTY_FULL;
    assign blue  = below_one ? 8'd0 : (below_two ? ramp : DUTY_FULL);
    assign red   = below_two ? 8'd0 : ramp;

endmodule

[design/rgb_status_led_sequencer.sv]
// an accepted tick beat waits in the input register until the duty registers take it
// throughput: one tick beat per cycle while out_stall is low, the input register feeding logic
// into the duty registers, which are also the output register
// reset: fades at zero and rising, fade counters saturated, duties zero,
// registers at their defaults, both channels empty
module rgb_status_led_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        powered,
    input  logic        show_level,
    input  logic [1:0]  link_state,
    input  logic        level_valid,
    input  logic [11:0] level,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  red_duty,
    output logic [7:0]  green_duty,
    output logic [7:0]  blue_duty,
    output logic        duty_changed,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata
);
    import rslseq_pkg::*;

    logic [7:0]   red_interval_reg, red_step_reg, blue_interval_reg, blue_step_reg;
    logic         s1_valid_reg;
    tick_beat_t   s1_reg;
    logic         out_valid_reg, out_valid_next;
    logic         cleared_reg, cleared_next;
    logic [7:0]   red_reg, red_next, green_reg, green_next, blue_reg, blue_next;
    logic         changed_reg, changed_next;
    logic         advance;
    logic         in_accept;
    logic         link_mode;
    logic         sel_red, sel_blue;
    fade_status_t red_fade, blue_fade;
    logic [7:0]   bar_red, bar_green, bar_blue;

    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_interval_reg  <= RED_INT_RST;
            red_step_reg      <= RED_STEP_RST;
            blue_interval_reg <= BLUE_INT_RST;
            blue_step_reg     <= BLUE_STEP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RED_INTERVAL:  red_interval_reg  <= cfg_wdata;
                REG_RED_STEP:      red_step_reg      <= cfg_wdata;
                REG_BLUE_INTERVAL: blue_interval_reg <= cfg_wdata;
                REG_BLUE_STEP:     blue_step_reg     <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept || advance)
        begin
            s1_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_reg.powered     <= powered;
            s1_reg.show_level  <= show_level;
            s1_reg.link_state  <= link_state;
            s1_reg.level_valid <= level_valid;
            s1_reg.level       <= level;
        end
    end

    assign link_mode = s1_reg.powered && !s1_reg.show_level;
    assign sel_red   = link_mode && (s1_reg.link_state == LINK_DOWN);
    // unused link code falls in with the other states
    assign sel_blue  = link_mode && (s1_reg.link_state != LINK_UP)
                     && (s1_reg.link_state != LINK_DOWN);

    rslseq_fade u_red_fade (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (advance),
        .sel      (sel_red),
        .interval (red_interval_reg),
        .step     (red_step_reg),
        .status   (red_fade)
    );

    rslseq_fade u_blue_fade (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (advance),
        .sel      (sel_blue),
        .interval (blue_interval_reg),
        .step     (blue_step_reg),
        .status   (blue_fade)
    );

    rslseq_bar u_bar (
        .level (s1_reg.level),
        .red   (bar_red),
        .green (bar_green),
        .blue  (bar_blue)
    );

    always_comb
    begin
        red_next     = red_reg;
        green_next   = green_reg;
        blue_next    = blue_reg;
        changed_next = 1'b0;
        cleared_next = cleared_reg;
        if (!s1_reg.powered)
        begin
            // clear once per power-off stretch
            if (!cleared_reg)
            begin
                red_next     = 8'd0;
                green_next   = 8'd0;
                blue_next    = 8'd0;
                changed_next = 1'b1;
                cleared_next = 1'b1;
            end
        end
        else
        begin
            cleared_next = 1'b0;
            if (!s1_reg.show_level)
            begin
                if (s1_reg.link_state == LINK_UP)
                begin
                    red_next     = 8'd0;
                    green_next   = DUTY_FULL;
                    blue_next    = 8'd0;
                    changed_next = 1'b1;
                end
                else if (red_fade.fire)
                begin
                    red_next     = red_fade.level;
                    green_next   = 8'd0;
                    blue_next    = 8'd0;
                    changed_next = 1'b1;
                end
                else if (blue_fade.fire)
                begin
                    red_next     = 8'd0;
                    green_next   = 8'd0;
                    blue_next    = blue_fade.level;
                    changed_next = 1'b1;
                end
            end
            else if (s1_reg.level_valid)
            begin
                red_next     = bar_red;
                green_next   = bar_green;
                blue_next    = bar_blue;
                changed_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cleared_reg   <= 1'b0;
            red_reg       <= 8'd0;
            green_reg     <= 8'd0;
            blue_reg      <= 8'd0;
            changed_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                cleared_reg <= cleared_next;
                red_reg     <= red_next;
                green_reg   <= green_next;
                blue_reg    <= blue_next;
                changed_reg <= changed_next;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign red_duty     = red_reg;
    assign green_duty   = green_reg;
    assign blue_duty    = blue_reg;
    assign duty_changed = changed_reg;

    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled with an empty input register");

    a_duty_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(red_reg) && $stable(green_reg) && $stable(blue_reg))
        else $error("duties moved without a beat");

    a_off_once: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !s1_reg.powered && cleared_reg |=> !changed_reg)
        else $error("power-off clear repeated");

    a_link_up: assert property (@(posedge clk) disable iff (!rst_n)
        advance && link_mode && s1_reg.link_state == LINK_UP
        |=> green_reg == DUTY_FULL && red_reg == 8'd0 && blue_reg == 8'd0)
        else $error("link up did not give full green");

endmodule

[bench/rgb_status_led_sequencer_checker.sv]
module rgb_status_led_sequencer_checker
    import rslseq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        powered,
    input  logic        show_level,
    input  logic [1:0]  link_state,
    input  logic        level_valid,
    input  logic [11:0] level,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  red_duty,
    input  logic [7:0]  green_duty,
    input  logic [7:0]  blue_duty,
    input  logic        duty_changed,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    output int unsigned waiting,
    output int unsigned errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       changed;
    } duty_beat_t;

    duty_beat_t duty_q[$];
    duty_beat_t want;
    tick_beat_t beat;

    logic [7:0] red_every, red_stride, blue_every, blue_stride;
    logic [7:0] red_lvl, blue_lvl;
    logic       red_down, blue_down;
    logic [7:0] red_age, blue_age;
    logic [7:0] hold_r, hold_g, hold_b;
    logic       dark;

    assign beat = {powered, show_level, link_state, level_valid, level};

    function automatic logic [7:0] ramp(logic [11:0] d);
        logic [31:0] q;
        q = (32'd51 * d + 32'd100) / 32'd200;
        return q[7:0];
    endfunction

    // returns {falling, level} after one fade step
    function automatic logic [8:0] fade_next(logic down, logic [7:0] lvl, logic [7:0] stride);
        logic signed [31:0] v;
        logic signed [31:0] s;
        logic               dn;
        dn = down;
        v = {24'd0, lvl};
        s = {24'd0, stride};
        v = down ? v - s : v + s;
        if (v >= 255)
        begin
            v = 255;
            dn = 1'b1;
        end
        if (v <= 0)
        begin
            v = 0;
            dn = 1'b0;
        end
        return {dn, v[7:0]};
    endfunction

    function automatic duty_beat_t next_duties(tick_beat_t t);
        duty_beat_t  d;
        logic [11:0] lv;
        d.changed = 1'b0;
        if (red_age != 8'd255)
            red_age = red_age + 8'd1;
        if (blue_age != 8'd255)
            blue_age = blue_age + 8'd1;

        if (!t.powered)
        begin
            // only the first dark tick rewrites the duties
            if (!dark)
            begin
                hold_r = 8'd0;
                hold_g = 8'd0;
                hold_b = 8'd0;
                dark = 1'b1;
                d.changed = 1'b1;
            end
        end
        else
        begin
            dark = 1'b0;
            if (!t.show_level)
            begin
                if (t.link_state == LINK_UP)
                begin
                    hold_r = 8'd0;
                    hold_g = DUTY_FULL;
                    hold_b = 8'd0;
                    d.changed = 1'b1;
                end
                else if (t.link_state == LINK_DOWN)
                begin
                    if (red_age >= red_every)
                    begin
                        red_age = 8'd0;
                        {red_down, red_lvl} = fade_next(red_down, red_lvl, red_stride);
                        hold_r = red_lvl;
                        hold_g = 8'd0;
                        hold_b = 8'd0;
                        d.changed = 1'b1;
                    end
                end
                else if (blue_age >= blue_every)
                begin
                    blue_age = 8'd0;
                    {blue_down, blue_lvl} = fade_next(blue_down, blue_lvl, blue_stride);
                    hold_r = 8'd0;
                    hold_g = 8'd0;
                    hold_b = blue_lvl;
                    d.changed = 1'b1;
                end
            end
            else if (t.level_valid)
            begin
                lv = (t.level > LEVEL_MAX) ? LEVEL_MAX : t.level;
                hold_g = (lv >= SEG_ONE) ? DUTY_FULL : ramp(lv);
                hold_b = (lv <= SEG_ONE) ? 8'd0 : (lv >= SEG_TWO) ? DUTY_FULL : ramp(lv - SEG_ONE);
                hold_r = (lv <= SEG_TWO) ? 8'd0 : ramp(lv - SEG_TWO);
                d.changed = 1'b1;
            end
        end
        d.red = hold_r;
        d.green = hold_g;
        d.blue = hold_b;
        return d;
    endfunction

    task automatic check_field(string what, logic [7:0] exp_v, logic [7:0] got_v);
        if (exp_v !== got_v)
        begin
            errors = errors + 1;
            $display("%0t ns: %s expected %0d, got %0d", $time, what, exp_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_every = RED_INT_RST;
            red_stride = RED_STEP_RST;
            blue_every = BLUE_INT_RST;
            blue_stride = BLUE_STEP_RST;
            red_lvl = 8'd0;
            blue_lvl = 8'd0;
            red_down = 1'b0;
            blue_down = 1'b0;
            red_age = 8'd255;
            blue_age = 8'd255;
            hold_r = 8'd0;
            hold_g = 8'd0;
            hold_b = 8'd0;
            dark = 1'b0;
            duty_q.delete();
            errors = 0;
            waiting <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_RED_INTERVAL:  red_every = cfg_wdata;
                    REG_RED_STEP:      red_stride = cfg_wdata;
                    REG_BLUE_INTERVAL: blue_every = cfg_wdata;
                    REG_BLUE_STEP:     blue_stride = cfg_wdata;
                    default:           ;
                endcase
            end
            if (in_valid && !in_stall)
                duty_q.push_back(next_duties(beat));
            if (out_valid && !out_stall)
            begin
                if (duty_q.size() == 0)
                begin
                    errors = errors + 1;
                    $display("%0t ns: duty beat expected none, got r%0d g%0d b%0d c%0d",
                             $time, red_duty, green_duty, blue_duty, duty_changed);
                end
                else
                begin
                    want = duty_q.pop_front();
                    check_field("red_duty", want.red, red_duty);
                    check_field("green_duty", want.green, green_duty);
                    check_field("blue_duty", want.blue, blue_duty);
                    check_field("duty_changed", {7'd0, want.changed}, {7'd0, duty_changed});
                end
            end
            waiting <= duty_q.size();
        end
    end

endmodule

[bench/tb_rgb_status_led_sequencer.sv]
module tb_rgb_status_led_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import rslseq_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned LONG_HOLD   = 400;
    localparam logic [1:0]  LINK_SPARE  = 2'd3;

    typedef enum int {RUN_OFF, RUN_UP, RUN_RED, RUN_BLUE, RUN_LEVEL} run_kind_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    tick_beat_t  tx;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  red_duty, green_duty, blue_duty;
    logic        duty_changed;
    logic        cfg_we;
    cfg_reg_t    cfg_index;
    logic [7:0]  cfg_wdata;

    int unsigned waiting, errors;
    int unsigned cycles = 0;
    bit          tx_gaps, rx_gaps;
    int unsigned holds_asked;
    int unsigned holds_done = 0;
    int unsigned rx_left = 0;

    rgb_status_led_sequencer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .powered      (tx.powered),
        .show_level   (tx.show_level),
        .link_state   (tx.link_state),
        .level_valid  (tx.level_valid),
        .level        (tx.level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .red_duty     (red_duty),
        .green_duty   (green_duty),
        .blue_duty    (blue_duty),
        .duty_changed (duty_changed),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    rgb_status_led_sequencer_checker duty_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .powered      (tx.powered),
        .show_level   (tx.show_level),
        .link_state   (tx.link_state),
        .level_valid  (tx.level_valid),
        .level        (tx.level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .red_duty     (red_duty),
        .green_duty   (green_duty),
        .blue_duty    (blue_duty),
        .duty_changed (duty_changed),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .waiting      (waiting),
        .errors       (errors)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: short random stall bursts, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (rx_left != 0)
        begin
            rx_left <= rx_left - 1;
            out_stall <= 1'b1;
        end
        else if (holds_asked != holds_done)
        begin
            holds_done <= holds_done + 1;
            rx_left <= LONG_HOLD;
            out_stall <= 1'b1;
        end
        else if (rx_gaps && $urandom_range(0, 7) == 0)
        begin
            rx_left <= $urandom_range(0, 3);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    function automatic tick_beat_t mk_tick(logic p, logic s, logic [1:0] link, logic v,
                                           logic [11:0] lvl);
        return {p, s, link, v, lvl};
    endfunction

    function automatic tick_beat_t rand_tick(run_kind_t kind);
        tick_beat_t  b;
        logic [31:0] r;
        logic [15:0] lv;
        b = mk_tick(1'b1, 1'b0, LINK_UP, 1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)));
        case (kind)
            RUN_OFF:
            begin
                b.powered = 1'b0;
                b.show_level = 1'($urandom_range(0, 1));
                b.link_state = 2'($urandom_range(0, 3));
            end
            RUN_RED:
                b.link_state = LINK_DOWN;
            RUN_BLUE:
                b.link_state = ($urandom_range(0, 3) == 0) ? LINK_SPARE : LINK_OTHER;
            RUN_LEVEL:
            begin
                b.show_level = 1'b1;
                b.level_valid = ($urandom_range(0, 4) != 0);
                // half of the samples sit close to a segment boundary
                if ($urandom_range(0, 1) == 0)
                begin
                    lv = 16'($urandom_range(0, 4) * 1000 + $urandom_range(0, 8));
                    lv = (lv >= 16'd4) ? lv - 16'd4 : lv;
                    b.level = (lv > 16'd4095) ? 12'd4095 : lv[11:0];
                end
            end
            default:
                ;
        endcase
        if ($urandom_range(0, 15) == 0)
        begin
            r = $urandom;
            b = r[16:0];
        end
        return b;
    endfunction

    task automatic offer(input tick_beat_t b);
        if (tx_gaps && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        tx <= b;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(input cfg_reg_t idx, input logic [7:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge clk);
    endtask

    task automatic load_regs(input logic [7:0] ri, input logic [7:0] rs,
                             input logic [7:0] bi, input logic [7:0] bs);
        put_reg(REG_RED_INTERVAL, ri);
        put_reg(REG_RED_STEP, rs);
        put_reg(REG_BLUE_INTERVAL, bi);
        put_reg(REG_BLUE_STEP, bs);
        cfg_we <= 1'b0;
    endtask

    task automatic random_ticks(input int unsigned count, input bit pressure);
        run_kind_t   kind;
        int unsigned left;
        int unsigned pick;
        left = 0;
        kind = RUN_RED;
        for (int unsigned n = 0; n < count; n++)
        begin
            if (left == 0)
            begin
                pick = $urandom_range(0, 99);
                kind = (pick < 10) ? RUN_OFF : (pick < 15) ? RUN_UP : (pick < 50) ? RUN_RED :
                       (pick < 85) ? RUN_BLUE : RUN_LEVEL;
                left = $urandom_range(1, 60);
            end
            left--;
            if (pressure && n == count / 3)
                holds_asked++;
            if (pressure && n == 2 * count / 3)
                settle();
            offer(rand_tick(kind));
        end
    endtask

    initial
    begin
        logic [11:0] ladder [13];
        ladder = '{12'd0, 12'd1, 12'd999, 12'd1000, 12'd1001, 12'd1999, 12'd2000,
                   12'd2001, 12'd2999, 12'd3000, 12'd3001, 12'd4000, 12'd4095};
        rst_n = 1'b0;
        in_valid = 1'b0;
        tx = '0;
        cfg_we = 1'b0;
        cfg_index = REG_RED_INTERVAL;
        cfg_wdata = 8'd0;
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        holds_asked = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // power off clears once, then holds
        offer(mk_tick(1'b0, 1'b0, LINK_UP, 1'b0, 12'd0));
        offer(mk_tick(1'b0, 1'b1, LINK_OTHER, 1'b1, 12'd4095));
        offer(mk_tick(1'b1, 1'b0, LINK_UP, 1'b0, 12'd0));
        // saturated counters make the first fade step immediate
        offer(mk_tick(1'b1, 1'b0, LINK_DOWN, 1'b0, 12'd0));
        offer(mk_tick(1'b1, 1'b0, LINK_DOWN, 1'b1, 12'd4095));
        offer(mk_tick(1'b1, 1'b0, LINK_OTHER, 1'b0, 12'd0));
        offer(mk_tick(1'b1, 1'b0, LINK_SPARE, 1'b0, 12'd0));
        // level mode without a sample holds
        offer(mk_tick(1'b1, 1'b1, LINK_UP, 1'b0, 12'd4095));
        foreach (ladder[i])
            offer(mk_tick(1'b1, 1'b1, LINK_DOWN, 1'b1, ladder[i]));
        offer(mk_tick(1'b0, 1'b1, LINK_UP, 1'b1, 12'd0));
        offer(mk_tick(1'b1, 1'b1, LINK_DOWN, 1'b0, 12'd0));
        offer(mk_tick(1'b0, 1'b0, LINK_SPARE, 1'b0, 12'd0));

        random_ticks(300, 1'b0);
        settle();

        for (int k = 0; k < 8; k++)
        begin
            case (k)
                0: load_regs(8'd1, 8'd1, 8'd1, 8'd1);
                1: load_regs(8'd255, 8'd255, 8'd255, 8'd255);
                2: load_regs(8'd0, 8'd0, 8'd0, 8'd0);
                3: load_regs(8'd2, 8'd37, 8'd3, 8'd64);
                7: load_regs(RED_INT_RST, RED_STEP_RST, BLUE_INT_RST, BLUE_STEP_RST);
                default: load_regs(8'($urandom_range(0, 12)), 8'($urandom_range(1, 255)),
                                   8'($urandom_range(0, 12)), 8'($urandom_range(1, 255)));
            endcase
            // no idling in the closing phase, and one quiet phase in three
            tx_gaps = (k != 7) && (k % 3 != 1);
            rx_gaps = tx_gaps;
            random_ticks(180, (k == 3) || (k == 5));
            settle();
        end

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
